[hdl/byte_stream_tokenizer_unit_macros.svh]
// assertion macros for the byte stream tokenizer
// used by files that carry concurrent checks; expects clock and reset in scope
`ifndef BYTE_STREAM_TOKENIZER_UNIT_MACROS_SVH
`define BYTE_STREAM_TOKENIZER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled during reset
`define BST_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BST_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define BST_ASSERT_IMP(label, ante, cons, msg)
`define BST_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

[hdl/bst_pkg.sv]
// shared types, character codes and classification functions
// for the byte stream tokenizer; no dependencies
`default_nettype none

package bst_pkg;

   // token kinds as carried on the result channel
   typedef enum logic [4:0] {
      TOK_ILLEGAL   = 5'd0,
      TOK_EOF       = 5'd1,
      TOK_IDENT     = 5'd2,
      TOK_INT       = 5'd3,
      TOK_ASSIGN    = 5'd4,
      TOK_PLUS      = 5'd5,
      TOK_MINUS     = 5'd6,
      TOK_BANG      = 5'd7,
      TOK_STAR      = 5'd8,
      TOK_SLASH     = 5'd9,
      TOK_LT        = 5'd10,
      TOK_GT        = 5'd11,
      TOK_COMMA     = 5'd12,
      TOK_SEMICOLON = 5'd13,
      TOK_LPAREN    = 5'd14,
      TOK_RPAREN    = 5'd15,
      TOK_LBRACE    = 5'd16,
      TOK_RBRACE    = 5'd17,
      TOK_EQ        = 5'd18,
      TOK_KEYWORD   = 5'd19
   } token_kind_type;

   // scanner modes
   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_IDENT = 2'd1,
      MODE_INT   = 2'd2,
      MODE_EQ    = 2'd3
   } scan_mode_type;

   // one result beat
   typedef struct packed {
      logic           last_of_run;
      logic [7:0]     token_char;
      logic [15:0]    token_length;
      logic [15:0]    start_pos;
      logic [2:0]     keyword_index;
      token_kind_type token_kind;
   } result_type;

   // character codes
   localparam logic [7:0] CHAR_END       = 8'h00;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_BANG      = 8'h21;
   localparam logic [7:0] CHAR_LPAREN    = 8'h28;
   localparam logic [7:0] CHAR_RPAREN    = 8'h29;
   localparam logic [7:0] CHAR_STAR      = 8'h2A;
   localparam logic [7:0] CHAR_PLUS      = 8'h2B;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_MINUS     = 8'h2D;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
   localparam logic [7:0] CHAR_LT        = 8'h3C;
   localparam logic [7:0] CHAR_EQUALS    = 8'h3D;
   localparam logic [7:0] CHAR_GT        = 8'h3E;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;

   // keyword registers and the result queue
   localparam int KEYWORD_WORD_BITS = 64;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_PTR_BITS    = 2;
   localparam int QUEUE_COUNT_BITS  = 3;
   localparam logic [15:0] LENGTH_MAX = 16'hFFFF;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) || c == CHAR_UNDERSCORE;
   endfunction

   function automatic logic is_decimal(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR;
   endfunction

   // kind of a single-character token, illegal for anything unlisted
   function automatic token_kind_type punct_kind(input logic [7:0] c);
      token_kind_type k;
      unique case (c)
         CHAR_PLUS:      k = TOK_PLUS;
         CHAR_MINUS:     k = TOK_MINUS;
         CHAR_BANG:      k = TOK_BANG;
         CHAR_STAR:      k = TOK_STAR;
         CHAR_SLASH:     k = TOK_SLASH;
         CHAR_LT:        k = TOK_LT;
         CHAR_GT:        k = TOK_GT;
         CHAR_COMMA:     k = TOK_COMMA;
         CHAR_SEMICOLON: k = TOK_SEMICOLON;
         CHAR_LPAREN:    k = TOK_LPAREN;
         CHAR_RPAREN:    k = TOK_RPAREN;
         CHAR_LBRACE:    k = TOK_LBRACE;
         CHAR_RBRACE:    k = TOK_RBRACE;
         default:        k = TOK_ILLEGAL;
      endcase
      return k;
   endfunction

   function automatic result_type make_result(input token_kind_type kind,
                                              input logic [2:0] kidx,
                                              input logic [15:0] start,
                                              input logic [15:0] len,
                                              input logic [7:0] ch);
      result_type r;
      r.token_kind    = kind;
      r.keyword_index = kidx;
      r.start_pos     = start;
      r.token_length  = len;
      r.token_char    = ch;
      r.last_of_run   = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

[hdl/bst_keyword_match.sv]
// keyword registers with their write port and the identifier compare
// depends on bst_pkg
`default_nettype none

module bst_keyword_match #(
   parameter int KEYWORD_SLOTS = 7,
   parameter int KEYWORD_CHARS = 8
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     csr_we,
   input  wire logic [bst_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  wire logic [bst_pkg::KEYWORD_WORD_BITS-1:0]    csr_wdata,
   input  wire logic [8*KEYWORD_CHARS-1:0]               ident_prefix,
   input  wire logic [15:0]                              run_length,
   input  wire logic                                     ident_overlong,
   output logic                                          kw_hit,
   output logic [2:0]                                    kw_index
);

   logic [bst_pkg::KEYWORD_WORD_BITS-1:0] keyword_ff [KEYWORD_SLOTS];
   logic [bst_pkg::KEYWORD_WORD_BITS-1:0] prefix_wide;
   logic                                  short_ident;

   // register writes; indexes past the slots fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEYWORD_SLOTS; k++) begin
            keyword_ff[k] <= '0;
         end
      end else if (csr_we) begin
         for (int k = 0; k < KEYWORD_SLOTS; k++) begin
            if (csr_index == bst_pkg::CSR_INDEX_BITS'(k)) begin
               keyword_ff[k] <= csr_wdata;
            end
         end
      end
   end

   assign prefix_wide = bst_pkg::KEYWORD_WORD_BITS'(ident_prefix);
   assign short_ident = !ident_overlong && (run_length <= 16'(KEYWORD_CHARS));

   // lowest matching nonzero slot wins
   always_comb begin
      kw_hit   = 1'b0;
      kw_index = '0;
      for (int k = KEYWORD_SLOTS - 1; k >= 0; k--) begin
         if (short_ident && keyword_ff[k] != '0 && keyword_ff[k] == prefix_wide) begin
            kw_hit   = 1'b1;
            kw_index = 3'(k);
         end
      end
   end

endmodule

`default_nettype wire

[hdl/bst_scanner.sv]
// scanner state and token building for one source byte per beat
// depends on bst_pkg; keyword result comes from bst_keyword_match
`default_nettype none

module bst_scanner #(
   parameter int POSITION_BITS = 16,
   parameter int KEYWORD_CHARS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         fire,
   input  wire logic [7:0]                   char_code,
   input  wire logic                         kw_hit,
   input  wire logic [2:0]                   kw_index,
   output logic [8*KEYWORD_CHARS-1:0]        ident_prefix,
   output logic [15:0]                       run_length,
   output logic                              ident_overlong,
   output logic [1:0]                        push_count,
   output bst_pkg::result_type               result_a,
   output bst_pkg::result_type               result_b
);

   localparam int PW = 8 * KEYWORD_CHARS;
   localparam int POS_WIDE = (POSITION_BITS > 16) ? POSITION_BITS : 16;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   bst_pkg::scan_mode_type    mode_ff, mode_in;
   logic [15:0]               run_start_ff, run_start_in;
   logic [15:0]               run_length_ff, run_length_in;
   logic [PW-1:0]             prefix_ff, prefix_in;
   logic                      overlong_ff, overlong_in;
   logic [POSITION_BITS-1:0]  pos_ff, pos_in;

   logic [POS_WIDE-1:0]       pos_wide;
   logic [15:0]               pos16;
   logic [15:0]               length_grown;
   logic                      handled;
   logic                      close_v, own_v;
   bst_pkg::result_type       close_tok, own_tok;

   assign pos_wide     = POS_WIDE'(pos_ff);
   assign pos16        = pos_wide[15:0];
   assign length_grown = (run_length_ff == bst_pkg::LENGTH_MAX) ? run_length_ff
                                                               : run_length_ff + 16'd1;

   assign ident_prefix   = prefix_ff;
   assign run_length     = run_length_ff;
   assign ident_overlong = overlong_ff;

   // next state and the tokens this byte produces
   always_comb begin
      mode_in      = mode_ff;
      run_start_in = run_start_ff;
      run_length_in = run_length_ff;
      prefix_in    = prefix_ff;
      overlong_in  = overlong_ff;
      pos_in       = pos_ff;
      handled      = 1'b0;
      close_v      = 1'b0;
      own_v        = 1'b0;
      close_tok    = bst_pkg::make_result(bst_pkg::TOK_ILLEGAL, 3'd0, 16'd0, 16'd0, 8'd0);
      own_tok      = close_tok;

      // close or extend an open token
      unique case (mode_ff)
         bst_pkg::MODE_IDENT: begin
            if (bst_pkg::is_alpha(char_code)) begin
               for (int i = 0; i < KEYWORD_CHARS; i++) begin
                  if (run_length_ff == 16'(i)) begin
                     prefix_in[8*i +: 8] = char_code;
                  end
               end
               if (run_length_ff >= 16'(KEYWORD_CHARS)) begin
                  overlong_in = 1'b1;
               end
               run_length_in = length_grown;
               handled = 1'b1;
            end else begin
               close_v   = 1'b1;
               close_tok = bst_pkg::make_result(
                  kw_hit ? bst_pkg::TOK_KEYWORD : bst_pkg::TOK_IDENT,
                  kw_hit ? kw_index : 3'd0, run_start_ff, run_length_ff, 8'd0);
               mode_in = bst_pkg::MODE_IDLE;
            end
         end
         bst_pkg::MODE_INT: begin
            if (bst_pkg::is_decimal(char_code)) begin
               run_length_in = length_grown;
               handled = 1'b1;
            end else begin
               close_v   = 1'b1;
               close_tok = bst_pkg::make_result(bst_pkg::TOK_INT, 3'd0, run_start_ff,
                                                run_length_ff, 8'd0);
               mode_in = bst_pkg::MODE_IDLE;
            end
         end
         bst_pkg::MODE_EQ: begin
            mode_in = bst_pkg::MODE_IDLE;
            close_v = 1'b1;
            if (char_code == bst_pkg::CHAR_EQUALS) begin
               close_tok = bst_pkg::make_result(bst_pkg::TOK_EQ, 3'd0, run_start_ff,
                                                16'd2, 8'd0);
               handled = 1'b1;
            end else begin
               close_tok = bst_pkg::make_result(bst_pkg::TOK_ASSIGN, 3'd0, run_start_ff,
                                                16'd1, bst_pkg::CHAR_EQUALS);
            end
         end
         default: begin
         end
      endcase

      // the byte's own meaning
      if (!handled) begin
         priority if (char_code == bst_pkg::CHAR_END) begin
            own_v   = 1'b1;
            own_tok = bst_pkg::make_result(bst_pkg::TOK_EOF, 3'd0, pos16, 16'd0, 8'd0);
         end else if (bst_pkg::is_space(char_code)) begin
         end else if (bst_pkg::is_alpha(char_code)) begin
            mode_in       = bst_pkg::MODE_IDENT;
            run_start_in  = pos16;
            run_length_in = 16'd1;
            prefix_in     = PW'(char_code);
            overlong_in   = 1'b0;
         end else if (bst_pkg::is_decimal(char_code)) begin
            mode_in       = bst_pkg::MODE_INT;
            run_start_in  = pos16;
            run_length_in = 16'd1;
         end else if (char_code == bst_pkg::CHAR_EQUALS) begin
            mode_in       = bst_pkg::MODE_EQ;
            run_start_in  = pos16;
            run_length_in = 16'd1;
         end else begin
            own_v   = 1'b1;
            own_tok = bst_pkg::make_result(bst_pkg::punct_kind(char_code), 3'd0, pos16,
                                           16'd1, char_code);
         end
      end

      // position restarts on end of input, else saturates
      if (char_code == bst_pkg::CHAR_END) begin
         pos_in  = '0;
         mode_in = bst_pkg::MODE_IDLE;
      end else if (pos_ff != POS_MAX) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   // order the beats and mark the last one
   always_comb begin
      result_a = close_v ? close_tok : own_tok;
      result_b = own_tok;
      if (close_v && own_v) begin
         push_count = 2'd2;
         result_a.last_of_run = 1'b0;
         result_b.last_of_run = 1'b1;
      end else if (close_v || own_v) begin
         push_count = 2'd1;
         result_a.last_of_run = 1'b1;
      end else begin
         push_count = 2'd0;
      end
      if (!fire) begin
         push_count = 2'd0;
      end
   end

   // scanner registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= bst_pkg::MODE_IDLE;
         run_start_ff  <= '0;
         run_length_ff <= '0;
         prefix_ff     <= '0;
         overlong_ff   <= 1'b0;
         pos_ff        <= '0;
      end else if (fire) begin
         mode_ff       <= mode_in;
         run_start_ff  <= run_start_in;
         run_length_ff <= run_length_in;
         prefix_ff     <= prefix_in;
         overlong_ff   <= overlong_in;
         pos_ff        <= pos_in;
      end
   end

endmodule

`default_nettype wire

[hdl/bst_result_queue.sv]
// four-entry result queue taking up to two beats per cycle
// depends on bst_pkg
`default_nettype none

module bst_result_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [1:0]           push_count,
   input  bst_pkg::result_type       result_a,
   input  bst_pkg::result_type       result_b,
   input  wire logic                 pop,
   output logic                      has_room,
   output logic                      head_valid,
   output bst_pkg::result_type       head
);

   bst_pkg::result_type                     entry_ff [bst_pkg::QUEUE_DEPTH];
   logic [bst_pkg::QUEUE_PTR_BITS-1:0]      head_ff, head_in;
   logic [bst_pkg::QUEUE_PTR_BITS-1:0]      tail_ff, tail_in;
   logic [bst_pkg::QUEUE_COUNT_BITS-1:0]    count_ff, count_in;
   logic                                    do_pop;

   // room for two more beats whatever the output side does
   assign has_room   = count_ff <= bst_pkg::QUEUE_COUNT_BITS'(bst_pkg::QUEUE_DEPTH - 2);
   assign head_valid = count_ff != '0;
   assign head       = entry_ff[head_ff];
   assign do_pop     = pop && head_valid;

   // pointer and count update
   always_comb begin
      head_in  = do_pop ? head_ff + 1'b1 : head_ff;
      tail_in  = tail_ff + bst_pkg::QUEUE_PTR_BITS'(push_count);
      count_in = count_ff + bst_pkg::QUEUE_COUNT_BITS'(push_count)
                 - bst_pkg::QUEUE_COUNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[tail_ff] <= result_a;
      end
      if (push_count == 2'd2) begin
         entry_ff[tail_ff + 1'b1] <= result_b;
      end
   end

endmodule

`default_nettype wire

[hdl/byte_stream_tokenizer_unit.sv]
// top level of the byte stream tokenizer
// depends on bst_pkg, bst_keyword_match, bst_scanner, bst_result_queue and the macro header
//
//   channel   direction  payload
//   req_      in         tdata[7:0] char_code
//   rsp_      out        tdata[42:0] token fields, tuser[4:0] token_kind, tlast last_of_run
//   csr_      in         we, index[2:0], wdata[63:0] keyword words
//
// one byte is taken per cycle while req_tready is high; its tokens enter the result
// queue on the same edge and, if the queue was empty, the first one is on rsp_ in the next cycle
// a byte that closes a token and makes its own gives two beats, so the byte stream
// runs at one byte per cycle while at most two beats per byte are produced
// req_tready drops when the four-entry result queue has fewer than two free slots
// reset clears scanner state, keyword words and the queue
`default_nettype none
`include "byte_stream_tokenizer_unit_macros.svh"

module byte_stream_tokenizer_unit #(
   parameter int POSITION_BITS = 16,
   parameter int KEYWORD_SLOTS = 7,
   parameter int KEYWORD_CHARS = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // char_code [7:0]
   input  wire logic [7:0]                             req_tdata,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // keyword_index [2:0], start_pos [18:3], token_length [34:19],
   // token_char [42:35], zero fill [47:43]
   output logic [47:0]                                 rsp_tdata,
   // token_kind [4:0]
   output logic [4:0]                                  rsp_tuser,
   output logic                                        rsp_tlast,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   input  wire logic                                   csr_we,
   input  wire logic [bst_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [bst_pkg::KEYWORD_WORD_BITS-1:0]  csr_wdata
);

   logic                        req_fire;
   logic [8*KEYWORD_CHARS-1:0]  ident_prefix;
   logic [15:0]                 run_length;
   logic                        ident_overlong;
   logic                        kw_hit;
   logic [2:0]                  kw_index;
   logic [1:0]                  push_count;
   bst_pkg::result_type         result_a, result_b, head;
   logic                        has_room;

   assign req_tready = has_room;
   assign req_fire   = req_tvalid && has_room;

   bst_keyword_match #(
      .KEYWORD_SLOTS (KEYWORD_SLOTS),
      .KEYWORD_CHARS (KEYWORD_CHARS)
   ) u_keyword (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .ident_prefix   (ident_prefix),
      .run_length     (run_length),
      .ident_overlong (ident_overlong),
      .kw_hit         (kw_hit),
      .kw_index       (kw_index)
   );

   bst_scanner #(
      .POSITION_BITS (POSITION_BITS),
      .KEYWORD_CHARS (KEYWORD_CHARS)
   ) u_scanner (
      .clock          (clock),
      .reset          (reset),
      .fire           (req_fire),
      .char_code      (req_tdata),
      .kw_hit         (kw_hit),
      .kw_index       (kw_index),
      .ident_prefix   (ident_prefix),
      .run_length     (run_length),
      .ident_overlong (ident_overlong),
      .push_count     (push_count),
      .result_a       (result_a),
      .result_b       (result_b)
   );

   bst_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .result_a   (result_a),
      .result_b   (result_b),
      .pop        (rsp_tready),
      .has_room   (has_room),
      .head_valid (rsp_tvalid),
      .head       (head)
   );

   // result beat packing
   assign rsp_tdata = {5'd0, head.token_char, head.token_length, head.start_pos,
                       head.keyword_index};
   assign rsp_tuser = head.token_kind;
   assign rsp_tlast = head.last_of_run;

   // end of input always yields at least the end token
   `BST_ASSERT_IMP(a_end_emits, req_fire && req_tdata == bst_pkg::CHAR_END, push_count != 2'd0, "end byte produced no token")

   // a two-beat byte marks only its second beat as last
   `BST_ASSERT_IMP(a_pair_last, push_count == 2'd2, !result_a.last_of_run && result_b.last_of_run, "bad last marking on token pair")

   // after a push, rsp_tvalid is high on the next cycle
   `BST_ASSERT_NXT(a_push_shows, push_count != 2'd0, rsp_tvalid, "pushed token not presented")

endmodule

`default_nettype wire

[tb/byte_stream_tokenizer_unit_check.sv]
// token checker for the byte stream tokenizer: keeps its own scanner state and keyword
// words, queues the tokens each accepted byte must give and compares every rsp_ beat
// depends on bst_pkg for the token kinds, scanner modes, result layout and char codes
module byte_stream_tokenizer_unit_check
   import bst_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   // char_code [7:0]
   input  wire logic [7:0]                   req_tdata,
   input  wire logic                         req_tvalid,
   input  wire logic                         req_tready,
   // keyword_index [2:0], start_pos [18:3], token_length [34:19],
   // token_char [42:35], zero fill [47:43]
   input  wire logic [47:0]                  rsp_tdata,
   // token_kind [4:0]
   input  wire logic [4:0]                   rsp_tuser,
   input  wire logic                         rsp_tlast,
   input  wire logic                         rsp_tvalid,
   input  wire logic                         rsp_tready,
   input  wire logic                         csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [KEYWORD_WORD_BITS-1:0] csr_wdata,
   output int                                fail_count,
   output int                                tokens_pending
);

   localparam int KEYWORD_REGS  = 7;
   localparam int KEYWORD_CHARS = 8;
   localparam logic [15:0] POSITION_MAX = 16'hFFFF;

   // mirrored keyword words and scanner state
   logic [63:0]   keyword_word [KEYWORD_REGS];
   scan_mode_type mode;
   logic [15:0]   run_start;
   logic [15:0]   run_length;
   logic [63:0]   prefix;
   logic          overlong;
   logic [15:0]   byte_pos;

   // tokens still owed by the block, oldest first
   result_type expected_tokens [$];

   function automatic logic ident_char(input logic [7:0] c);
      return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) || c == CHAR_UNDERSCORE;
   endfunction

   function automatic logic digit_char(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic logic skip_char(input logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR;
   endfunction

   function automatic token_kind_type symbol_kind(input logic [7:0] c);
      case (c)
         CHAR_PLUS:      return TOK_PLUS;
         CHAR_MINUS:     return TOK_MINUS;
         CHAR_BANG:      return TOK_BANG;
         CHAR_STAR:      return TOK_STAR;
         CHAR_SLASH:     return TOK_SLASH;
         CHAR_LT:        return TOK_LT;
         CHAR_GT:        return TOK_GT;
         CHAR_COMMA:     return TOK_COMMA;
         CHAR_SEMICOLON: return TOK_SEMICOLON;
         CHAR_LPAREN:    return TOK_LPAREN;
         CHAR_RPAREN:    return TOK_RPAREN;
         CHAR_LBRACE:    return TOK_LBRACE;
         CHAR_RBRACE:    return TOK_RBRACE;
         default:        return TOK_ILLEGAL;
      endcase
   endfunction

   function automatic void queue_token(input token_kind_type kind, input logic [2:0] slot,
                                       input logic [15:0] start, input logic [15:0] len,
                                       input logic [7:0] ch);
      result_type t;
      t.token_kind    = kind;
      t.keyword_index = slot;
      t.start_pos     = start;
      t.token_length  = len;
      t.token_char    = ch;
      t.last_of_run   = 1'b0;
      expected_tokens.push_back(t);
   endfunction

   // identifier or keyword; scanning down so the lowest matching slot wins
   function automatic void close_ident();
      token_kind_type kind;
      logic [2:0]     slot;
      kind = TOK_IDENT;
      slot = 3'd0;
      if (!overlong && run_length <= KEYWORD_CHARS) begin
         for (int k = KEYWORD_REGS - 1; k >= 0; k--) begin
            if (keyword_word[k] != 64'd0 && keyword_word[k] == prefix) begin
               kind = TOK_KEYWORD;
               slot = k[2:0];
            end
         end
      end
      queue_token(kind, slot, run_start, run_length, 8'd0);
   endfunction

   function automatic void grow_run();
      if (run_length != LENGTH_MAX)
         run_length = run_length + 16'd1;
   endfunction

   // advance the mirrored scanner by one byte and queue what it closes or makes
   function automatic void scan_byte(input logic [7:0] c);
      int         queued_before;
      logic       taken;
      result_type t;
      queued_before = expected_tokens.size();
      taken = 1'b0;

      // a byte that does not continue the open token closes it first
      case (mode)
         MODE_IDENT: begin
            if (ident_char(c)) begin
               if (run_length < KEYWORD_CHARS)
                  prefix[8*run_length +: 8] = c;
               else
                  overlong = 1'b1;
               grow_run();
               taken = 1'b1;
            end else begin
               close_ident();
               mode = MODE_IDLE;
            end
         end
         MODE_INT: begin
            if (digit_char(c)) begin
               grow_run();
               taken = 1'b1;
            end else begin
               queue_token(TOK_INT, 3'd0, run_start, run_length, 8'd0);
               mode = MODE_IDLE;
            end
         end
         MODE_EQ: begin
            mode = MODE_IDLE;
            if (c == CHAR_EQUALS) begin
               queue_token(TOK_EQ, 3'd0, run_start, 16'd2, 8'd0);
               taken = 1'b1;
            end else begin
               queue_token(TOK_ASSIGN, 3'd0, run_start, 16'd1, CHAR_EQUALS);
            end
         end
         default: ;
      endcase

      // the byte's own token, or the start of a new run
      if (!taken) begin
         if (c == CHAR_END) begin
            queue_token(TOK_EOF, 3'd0, byte_pos, 16'd0, 8'd0);
         end else if (skip_char(c)) begin
         end else if (ident_char(c)) begin
            mode       = MODE_IDENT;
            run_start  = byte_pos;
            run_length = 16'd1;
            prefix     = {56'd0, c};
            overlong   = 1'b0;
         end else if (digit_char(c)) begin
            mode       = MODE_INT;
            run_start  = byte_pos;
            run_length = 16'd1;
         end else if (c == CHAR_EQUALS) begin
            mode       = MODE_EQ;
            run_start  = byte_pos;
            run_length = 16'd1;
         end else begin
            queue_token(symbol_kind(c), 3'd0, byte_pos, 16'd1, c);
         end
      end

      // end of input restarts the position, which otherwise saturates
      if (c == CHAR_END) begin
         byte_pos = 16'd0;
         mode     = MODE_IDLE;
      end else if (byte_pos != POSITION_MAX) begin
         byte_pos = byte_pos + 16'd1;
      end

      // flag the last token this byte caused
      if (expected_tokens.size() > queued_before) begin
         t = expected_tokens.pop_back();
         t.last_of_run = 1'b1;
         expected_tokens.push_back(t);
      end
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // compare a result beat with the oldest owed token
   function automatic void check_token(input result_type seen);
      result_type want;
      if (expected_tokens.size() == 0) begin
         $error("token beat with nothing owed: kind %0d start %0d",
                seen.token_kind, seen.start_pos);
         fail_count++;
      end else begin
         want = expected_tokens.pop_front();
         check_field("token_kind", 32'(want.token_kind), 32'(seen.token_kind));
         check_field("keyword_index", 32'(want.keyword_index), 32'(seen.keyword_index));
         check_field("start_pos", 32'(want.start_pos), 32'(seen.start_pos));
         check_field("token_length", 32'(want.token_length), 32'(seen.token_length));
         check_field("token_char", 32'(want.token_char), 32'(seen.token_char));
         check_field("last_of_run", 32'(want.last_of_run), 32'(seen.last_of_run));
      end
   endfunction

   // watch all three ports on each rising edge
   always @(posedge clock) begin
      if (reset) begin
         foreach (keyword_word[k])
            keyword_word[k] = 64'd0;
         mode       = MODE_IDLE;
         run_start  = 16'd0;
         run_length = 16'd0;
         prefix     = 64'd0;
         overlong   = 1'b0;
         byte_pos   = 16'd0;
         expected_tokens.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_token({rsp_tlast, rsp_tdata[42:0], rsp_tuser});
         // index past the last keyword word is ignored
         if (csr_we && csr_index < KEYWORD_REGS)
            keyword_word[csr_index] = csr_wdata;
         if (req_tvalid && req_tready)
            scan_byte(req_tdata);
      end
      tokens_pending <= expected_tokens.size();
   end

endmodule

[tb/byte_stream_tokenizer_unit_test.sv]
// testbench top for the byte stream tokenizer: drives source bytes and keyword words,
// throttles both channels and gives the verdict from the token checker's failure count
// depends on bst_pkg, byte_stream_tokenizer_unit and byte_stream_tokenizer_unit_check
module byte_stream_tokenizer_unit_test;
   import bst_pkg::*;

   localparam int KEYWORD_REGS    = 7;
   localparam logic [2:0] UNUSED_INDEX = 3'd7;
   localparam int PHASE_BYTES     = 245;
   localparam int RANDOM_PHASES   = 6;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_CYCLES    = 10;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int LONG_RUN_BYTES  = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] rsp_tdata;
   logic [4:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]    csr_index = '0;
   logic [KEYWORD_WORD_BITS-1:0] csr_wdata = '0;

   int fail_count;
   int tokens_pending;
   int stalled_cycles = 0;

   // throttle controls: quiet_phase for the sender and the receiver, hold_off_request for the receiver
   logic quiet_phase = 1'b0;
   logic hold_off_request = 1'b0;

   // keyword words as last programmed, also the vocabulary for identifiers
   logic [63:0] kw_now [KEYWORD_REGS];

   logic [7:0] punct_bytes [13] = '{CHAR_PLUS, CHAR_MINUS, CHAR_BANG, CHAR_STAR, CHAR_SLASH,
                                    CHAR_LT, CHAR_GT, CHAR_COMMA, CHAR_SEMICOLON, CHAR_LPAREN,
                                    CHAR_RPAREN, CHAR_LBRACE, CHAR_RBRACE};

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   byte_stream_tokenizer_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   byte_stream_tokenizer_unit_check token_check (
      .clock          (clock),
      .reset          (reset),
      .req_tdata      (req_tdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .tokens_pending (tokens_pending)
   );

   // mostly no gap, sometimes a short one, rarely a long one
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] pack_word(input string s);
      logic [63:0] w;
      w = 64'd0;
      for (int i = 0; i < s.len() && i < 8; i++)
         w[8*i +: 8] = s[i];
      return w;
   endfunction

   function automatic logic [7:0] random_letter();
      int r;
      logic [7:0] c;
      r = $urandom_range(0, 52);
      if (r < 26)
         c = CHAR_LOWER_A + 8'(r);
      else if (r < 52)
         c = CHAR_UPPER_A + 8'(r - 26);
      else
         c = CHAR_UNDERSCORE;
      return c;
   endfunction

   // offer one byte, after an optional gap, and hold it until the beat is taken
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = quiet_phase ? 0 : idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   // stop offering, wait for every owed token, then let the block go quiet
   task automatic settle_tokens();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tokens_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all keyword words, then one write past the end that must be ignored
   task automatic program_keywords();
      for (int i = 0; i < KEYWORD_REGS; i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= kw_now[i];
         @(posedge clock);
      end
      csr_index <= UNUSED_INDEX;
      csr_wdata <= {$urandom, $urandom};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // mix of letter words, copies of lower slots, zero and raw 64-bit values
   task automatic pick_keywords();
      int r, n;
      for (int k = 0; k < KEYWORD_REGS; k++) begin
         r = $urandom_range(0, 9);
         if (r == 6) begin
            kw_now[k] = 64'd0;
         end else if (r == 7) begin
            kw_now[k] = {$urandom, $urandom};
         end else if (r >= 8 && k > 0) begin
            kw_now[k] = kw_now[$urandom_range(0, k - 1)];
         end else begin
            kw_now[k] = 64'd0;
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
               kw_now[k][8*i +: 8] = random_letter();
         end
      end
   endtask

   // token-shaped stream with random content, closed by an end byte
   task automatic random_phase(input int budget);
      int sent, pick, n;
      logic [63:0] w;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            if ($urandom_range(0, 1) == 1) begin
               // configured word, sometimes with one more letter
               w = kw_now[$urandom_range(0, KEYWORD_REGS - 1)];
               for (int i = 0; i < 8; i++) begin
                  if (w[8*i +: 8] != 8'd0) begin
                     send_byte(w[8*i +: 8]);
                     sent++;
                  end
               end
               if ($urandom_range(0, 4) == 0) begin
                  send_byte(random_letter());
                  sent++;
               end
            end else begin
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
               repeat (n) begin
                  send_byte(random_letter());
                  sent++;
               end
            end
         end else if (pick < 45) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
               sent++;
            end
         end else if (pick < 55) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
               send_byte(CHAR_EQUALS);
               sent++;
            end
         end else if (pick < 75) begin
            send_byte(punct_bytes[$urandom_range(0, 12)]);
            sent++;
         end else if (pick < 88) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
               case ($urandom_range(0, 3))
                  0:       send_byte(CHAR_SPACE);
                  1:       send_byte(CHAR_TAB);
                  2:       send_byte(CHAR_LF);
                  default: send_byte(CHAR_CR);
               endcase
               sent++;
            end
         end else if (pick < 97) begin
            send_byte(8'($urandom_range(1, 255)));
            sent++;
         end else begin
            send_byte(CHAR_END);
            sent++;
         end
      end
      send_byte(CHAR_END);
   endtask

   // receiver: random ready pattern, one long hold-off on request
   initial begin : token_sink
      int   n;
      logic level;
      logic held;
      held = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_request && !held) begin
            held  = 1'b1;
            level = 1'b0;
            n     = HOLD_OFF_CYCLES;
         end else if (quiet_phase) begin
            level = 1'b1;
            n     = 1;
         end else begin
            n = idle_cycles();
            if (n == 0) begin
               level = 1'b1;
               n     = $urandom_range(1, 8);
            end else begin
               level = 1'b0;
            end
         end
         rsp_tready <= level;
         repeat (n) @(posedge clock);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : byte_source
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: max-length keyword, int after keyword, eq, one-char keyword,
      // assign closed by a symbol, every symbol, blanks, illegal bytes, end after '='
      kw_now = '{pack_word("fn"), pack_word("let"), pack_word("if"), pack_word("else"),
                 pack_word("return"), pack_word("continue"), pack_word("x")};
      program_keywords();
      send_text("continue9==x=+-!*/<>,;(){}\t\r\n @");
      send_byte(8'hFF);
      send_byte(CHAR_EQUALS);
      send_byte(CHAR_END);
      settle_tokens();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0)
            // all-ones word, word with an inner zero, duplicate with lower slot winning
            kw_now = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_6200_0061, pack_word("ab"),
                       pack_word("ab"), 64'd0, pack_word("zzzzzzzz"), pack_word("Z_")};
         else if (p == RANDOM_PHASES - 1)
            kw_now = '{default: 64'd0};
         else
            pick_keywords();
         program_keywords();
         if (p == 1)
            hold_off_request <= 1'b1;
         if (p == 3)
            quiet_phase <= 1'b1;
         random_phase(PHASE_BYTES);
         settle_tokens();
         quiet_phase <= 1'b0;
      end

      // identifier well past the keyword width, then int, eq and a keyword after an end
      kw_now = '{pack_word("fn"), pack_word("let"), pack_word("if"), pack_word("else"),
                 pack_word("return"), pack_word("continue"), pack_word("x")};
      program_keywords();
      quiet_phase <= 1'b1;
      repeat (LONG_RUN_BYTES) send_byte(CHAR_LOWER_A);
      send_text("7==");
      send_byte(CHAR_END);
      send_text("if");
      send_byte(CHAR_END);
      settle_tokens();
      quiet_phase <= 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && tokens_pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
